### sv/itaf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the integer to ASCII formatter.
// Depends on nothing; every other file of the block uses it by scoped names.

package itaf_pkg;

	// Format selector codes carried by the func field.
	localparam logic [2:0] FUNC_SDEC = 3'd0;
	localparam logic [2:0] FUNC_DEC4 = 3'd1;
	localparam logic [2:0] FUNC_BIN8 = 3'd2;
	localparam logic [2:0] FUNC_BINS = 3'd3;
	localparam logic [2:0] FUNC_HEX  = 3'd4;

	// ASCII characters used by the formats.
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [3:0] NIB_MAX_DEC = 4'd9;
	localparam logic [6:0] HEX_LETTER_BASE = 7'd10;

	// Divide by ten through a reciprocal: q = (x * RECIP_10) >> RECIP_SHIFT,
	// exact for every 32-bit unsigned x.
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	// Digit buffer holds all decimal digits of a 32-bit magnitude.
	localparam int MAX_DIGITS = 10;
	localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
	localparam logic [DIG_IDX_W-1:0] DEC4_LAST_IDX = DIG_IDX_W'(3);

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		K_DEC,
		K_DEC4,
		K_BIN8,
		K_BINS,
		K_HEX
	} kind_t;

	// One classified item as handed from the front to the back.
	typedef struct packed {
		kind_t       kind;
		logic        neg;
		logic [31:0] mag;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIG,
		ST_EMIT
	} state_t;

	// Uppercase hex character for one nibble.
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] res;
		if (nib <= NIB_MAX_DEC) begin
			res = CH_ZERO + {3'b000, nib};
		end else begin
			res = CH_UPPER_A + {3'b000, nib} - HEX_LETTER_BASE;
		end
		return res;
	endfunction

endpackage

### sv/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// Integer to ASCII formatter top level: front end, command queue and back end.
// Depends on itaf_pkg, itaf_front, itaf_queue and itaf_back.

// Each item carries a format selector and a 32-bit value and yields its ASCII
// characters most significant first, one per output item, with last set on
// the final one. Formats: signed decimal, four-digit decimal (low 16 bits
// modulo 10000), eight-bit binary, short binary (nothing for zero) and two
// uppercase hex digits; unused selectors give no output. The front end takes
// one item per cycle, while in_stall is low, into a two-entry queue. The back
// end picks up an item, then for each decimal digit runs its divide-by-ten
// loop (multiply, then remainder), then emits the characters one by one while
// the output is not stalled.

module integer_to_ascii_formatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         ascii_char,
	output logic               last
);

	logic           push;
	itaf_pkg::cmd_t push_cmd;
	logic           queue_full;
	logic           cmd_pop;
	logic           cmd_avail;
	itaf_pkg::cmd_t head_cmd;

	// Item intake and classification.
	itaf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.value      (value),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// Decoupling queue.
	itaf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (cmd_pop),
		.avail    (cmd_avail),
		.head_cmd (head_cmd)
	);

	// Digit conversion and character output.
	itaf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (cmd_avail),
		.cmd        (head_cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ascii_char (ascii_char),
		.last       (last)
	);

endmodule

### sv/itaf_front.sv
`timescale 1ns / 1ps
// Front end of the formatter: accepts items, classifies them by format and
// builds the magnitude to convert. Depends on itaf_pkg.

module itaf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          func,
	input  logic signed [31:0]  value,
	output logic                push,
	output itaf_pkg::cmd_t      push_cmd,
	input  logic                queue_full
);

	logic           valid_s1;
	itaf_pkg::cmd_t cmd_s1;
	itaf_pkg::cmd_t cmd_new;
	logic           keep_new;
	logic [31:0]    val_u;
	logic           accept;

	assign val_u = unsigned'(value);

	// Classify the incoming item; items that give no characters are dropped.
	always_comb begin
		cmd_new.kind = itaf_pkg::K_HEX;
		cmd_new.neg  = 1'b0;
		cmd_new.mag  = {24'b0, val_u[7:0]};
		keep_new     = 1'b1;
		case (func)
			itaf_pkg::FUNC_SDEC: begin
				cmd_new.kind = itaf_pkg::K_DEC;
				cmd_new.neg  = val_u[31];
				cmd_new.mag  = val_u[31] ? (~val_u + 32'd1) : val_u;
			end
			itaf_pkg::FUNC_DEC4: begin
				cmd_new.kind = itaf_pkg::K_DEC4;
				cmd_new.mag  = {16'b0, val_u[15:0]};
			end
			itaf_pkg::FUNC_BIN8: begin
				cmd_new.kind = itaf_pkg::K_BIN8;
			end
			itaf_pkg::FUNC_BINS: begin
				cmd_new.kind = itaf_pkg::K_BINS;
				keep_new     = (val_u[7:0] != 8'd0);
			end
			itaf_pkg::FUNC_HEX: begin
				cmd_new.kind = itaf_pkg::K_HEX;
			end
			default: begin
				keep_new = 1'b0;
			end
		endcase
	end

	// The stage holds while its item cannot enter the queue.
	assign in_stall = valid_s1 && queue_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !queue_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep_new;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

### sv/itaf_queue.sv
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the back end.
// Depends on itaf_pkg for the command type and the queue depth.

module itaf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  itaf_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output itaf_pkg::cmd_t head_cmd
);

	itaf_pkg::cmd_t                     entry_q [itaf_pkg::QUEUE_DEPTH];
	logic [itaf_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [itaf_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [itaf_pkg::QUEUE_CNT_W-1:0]   count_q;

	localparam logic [itaf_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
		itaf_pkg::QUEUE_PTR_W'(itaf_pkg::QUEUE_DEPTH - 1);
	localparam logic [itaf_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
		itaf_pkg::QUEUE_CNT_W'(itaf_pkg::QUEUE_DEPTH);

	assign full     = (count_q == CNT_FULL);
	assign avail    = (count_q != '0);
	assign head_cmd = entry_q[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### sv/itaf_back.sv
`timescale 1ns / 1ps
// Back end of the formatter: converts magnitudes to decimal digits one digit
// at a time and emits the characters of each item. Depends on itaf_pkg.

module itaf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_avail,
	input  itaf_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [6:0]     ascii_char,
	output logic           last
);

	itaf_pkg::state_t state_q, state_d;
	itaf_pkg::kind_t  kind_q, kind_d;
	logic             neg_q, neg_d;
	logic [31:0]      mag_q, mag_d;
	logic [31:0]      quot_q, quot_d;
	logic [itaf_pkg::DIG_IDX_W-1:0] nd_q, nd_d;
	logic [itaf_pkg::DIG_IDX_W-1:0] idx_q, idx_d;
	logic [3:0]       digit_q [itaf_pkg::MAX_DIGITS];
	logic             out_valid_q, out_valid_d;
	logic [6:0]       char_q, char_d;
	logic             last_q, last_d;

	logic [63:0]      prod;
	logic [31:0]      rem;
	logic             dig_we;
	logic             dig_done;
	logic             out_free;
	logic [2:0]       msb_pos;
	logic [6:0]       emit_char;

	assign out_free = !out_valid_q || !out_stall;

	// Reciprocal product for the divide by ten; the quotient taken from it is registered before use.
	assign prod = mag_q * itaf_pkg::RECIP_10;

	// Remainder of the divide by ten gives the next digit.
	assign rem = mag_q - ((quot_q << 3) + (quot_q << 1));

	assign dig_done = (kind_q == itaf_pkg::K_DEC) ? (quot_q == 32'd0)
	                                             : (nd_q == itaf_pkg::DEC4_LAST_IDX);

	// Highest set bit of the low byte, for short binary.
	always_comb begin
		msb_pos = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (cmd.mag[i]) begin
				msb_pos = 3'(i);
			end
		end
	end

	// Character at the current emit position.
	always_comb begin
		case (kind_q)
			itaf_pkg::K_DEC, itaf_pkg::K_DEC4: begin
				emit_char = itaf_pkg::CH_ZERO + {3'b000, digit_q[idx_q]};
			end
			itaf_pkg::K_BIN8, itaf_pkg::K_BINS: begin
				emit_char = itaf_pkg::CH_ZERO + {6'b0, mag_q[idx_q[2:0]]};
			end
			itaf_pkg::K_HEX: begin
				emit_char = itaf_pkg::hex_char(idx_q[0] ? mag_q[7:4] : mag_q[3:0]);
			end
			default: begin
				emit_char = itaf_pkg::CH_ZERO;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itaf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state, working registers and output register contents.
	always_comb begin
		state_d     = state_q;
		kind_d      = kind_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		quot_d      = quot_q;
		nd_d        = nd_q;
		idx_d       = idx_q;
		out_valid_d = out_valid_q && out_stall;
		char_d      = char_q;
		last_d      = last_q;
		cmd_pop     = 1'b0;
		dig_we      = 1'b0;
		case (state_q)
			itaf_pkg::ST_IDLE: begin
				if (cmd_avail) begin
					cmd_pop = 1'b1;
					kind_d  = cmd.kind;
					neg_d   = cmd.neg;
					mag_d   = cmd.mag;
					nd_d    = '0;
					case (cmd.kind)
						itaf_pkg::K_DEC, itaf_pkg::K_DEC4: begin
							state_d = itaf_pkg::ST_MUL;
						end
						itaf_pkg::K_BIN8: begin
							state_d = itaf_pkg::ST_EMIT;
							idx_d   = itaf_pkg::DIG_IDX_W'(7);
						end
						itaf_pkg::K_BINS: begin
							state_d = itaf_pkg::ST_EMIT;
							idx_d   = itaf_pkg::DIG_IDX_W'(msb_pos);
						end
						default: begin
							state_d = itaf_pkg::ST_EMIT;
							idx_d   = itaf_pkg::DIG_IDX_W'(1);
						end
					endcase
				end
			end
			itaf_pkg::ST_MUL: begin
				quot_d  = 32'(prod >> itaf_pkg::RECIP_SHIFT);
				state_d = itaf_pkg::ST_DIG;
			end
			itaf_pkg::ST_DIG: begin
				// Store one digit, least significant first.
				dig_we = 1'b1;
				mag_d  = quot_q;
				nd_d   = nd_q + 1'b1;
				if (dig_done) begin
					idx_d   = nd_q;
					state_d = itaf_pkg::ST_EMIT;
				end else begin
					state_d = itaf_pkg::ST_MUL;
				end
			end
			itaf_pkg::ST_EMIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					if (neg_q) begin
						char_d = itaf_pkg::CH_MINUS;
						last_d = 1'b0;
						neg_d  = 1'b0;
					end else begin
						char_d = emit_char;
						last_d = (idx_q == '0);
						if (idx_q == '0) begin
							state_d = itaf_pkg::ST_IDLE;
						end else begin
							idx_d = idx_q - 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = itaf_pkg::ST_IDLE;
			end
		endcase
	end

	// Working and output payload registers.
	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		neg_q  <= neg_d;
		mag_q  <= mag_d;
		quot_q <= quot_d;
		nd_q   <= nd_d;
		idx_q  <= idx_d;
		char_q <= char_d;
		last_q <= last_d;
		if (dig_we) begin
			digit_q[nd_q] <= rem[3:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last       = last_q;

endmodule

### tb/integer_to_ascii_formatter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the integer to ASCII formatter: a character scoreboard
// predicts every output character and checks it under random input gaps and output stalls.
// Depends on itaf_pkg and integer_to_ascii_formatter.

// One output character together with its end-of-item flag.
typedef struct packed {
	logic [6:0] ch;
	logic       last;
} ascii_item_t;

// Predicts the characters of each accepted item and checks the block's output against them.
class char_ledger;
	ascii_item_t expected_chars[$];
	int failures;
	int checked;

	function new();
		failures = 0;
		checked = 0;
	endfunction

	// ASCII character for one decimal or binary digit.
	function logic [6:0] digit_char(int unsigned d);
		return itaf_pkg::CH_ZERO + 7'(d);
	endfunction

	// Works out every character one accepted item should produce and queues them.
	function void note_item(logic [2:0] fmt, logic [31:0] num);
		ascii_item_t chars[$];
		int unsigned digs[$];
		logic [31:0] mag;
		int unsigned low4;
		logic [3:0] nib;
		logic seen;
		case (fmt)
		itaf_pkg::FUNC_SDEC: begin
			if (num == 32'd0) begin
				chars.push_back('{ch: itaf_pkg::CH_ZERO, last: 1'b0});
			end else begin
				// The most negative value negates to itself, which is 2^31 unsigned.
				mag = num[31] ? (~num + 32'd1) : num;
				if (num[31]) begin
					chars.push_back('{ch: itaf_pkg::CH_MINUS, last: 1'b0});
				end
				while (mag != 32'd0) begin
					digs.push_front(mag % 10);
					mag = mag / 10;
				end
				foreach (digs[i]) begin
					chars.push_back('{ch: digit_char(digs[i]), last: 1'b0});
				end
			end
		end
		itaf_pkg::FUNC_DEC4: begin
			low4 = num[15:0] % 10000;
			chars.push_back('{ch: digit_char(low4 / 1000), last: 1'b0});
			chars.push_back('{ch: digit_char((low4 / 100) % 10), last: 1'b0});
			chars.push_back('{ch: digit_char((low4 / 10) % 10), last: 1'b0});
			chars.push_back('{ch: digit_char(low4 % 10), last: 1'b0});
		end
		itaf_pkg::FUNC_BIN8: begin
			for (int i = 7; i >= 0; i--) begin
				chars.push_back('{ch: digit_char(num[i]), last: 1'b0});
			end
		end
		itaf_pkg::FUNC_BINS: begin
			// Leading zeros are dropped, so a zero byte gives no characters.
			seen = 1'b0;
			for (int i = 7; i >= 0; i--) begin
				if (num[i]) begin
					seen = 1'b1;
				end
				if (seen) begin
					chars.push_back('{ch: digit_char(num[i]), last: 1'b0});
				end
			end
		end
		itaf_pkg::FUNC_HEX: begin
			for (int i = 1; i >= 0; i--) begin
				nib = num[i*4 +: 4];
				if (nib <= itaf_pkg::NIB_MAX_DEC) begin
					chars.push_back('{ch: itaf_pkg::CH_ZERO + {3'b000, nib}, last: 1'b0});
				end else begin
					chars.push_back('{ch: itaf_pkg::CH_UPPER_A + {3'b000, nib}
						- itaf_pkg::HEX_LETTER_BASE, last: 1'b0});
				end
			end
		end
		default: begin
		end
		endcase
		if (chars.size() > 0) begin
			chars[chars.size() - 1].last = 1'b1;
		end
		foreach (chars[i]) begin
			expected_chars.push_back(chars[i]);
		end
	endfunction

	// Compares one output character with the oldest prediction.
	function void check_char(logic [6:0] ch, logic lst);
		ascii_item_t want;
		checked++;
		if (expected_chars.size() == 0) begin
			failures++;
			$error("ascii_char: no character expected, actual %h (last %b)", ch, lst);
			return;
		end
		want = expected_chars.pop_front();
		if (ch !== want.ch) begin
			failures++;
			$error("ascii_char: expected %h, actual %h", want.ch, ch);
		end
		if (lst !== want.last) begin
			failures++;
			$error("last: expected %b, actual %b", want.last, lst);
		end
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction
endclass

module integer_to_ascii_formatter_test;

	// Selector codes the block does not use; items carrying them are dropped.
	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
	localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ITEMS   = 40;
	localparam int BURST_ITEMS   = 16;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         func;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [6:0]         ascii_char;
	logic               last;

	char_ledger ledger = new();
	int send_idle_pct;
	int recv_stall_pct;
	logic hold_on;
	int cycles;
	int items_sent;
	int items_ignored;

	integer_to_ascii_formatter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ascii_char (ascii_char),
		.last       (last)
	);

	// Free-running 10 ns clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Known values on every input from time zero.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = itaf_pkg::FUNC_SDEC;
		value = 32'sd0;
		out_stall = 1'b0;
		hold_on = 1'b0;
		recv_stall_pct = 0;
		send_idle_pct = 0;
		cycles = 0;
		items_sent = 0;
		items_ignored = 0;
	end

	// Receiver: random stalls, plus a forced hold-off when requested.
	always @(posedge clk) begin
		out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Every accepted output character is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			ledger.check_char(ascii_char, last);
		end
	end

	// Run-time guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one item, with random idle cycles first, and waits until it is taken.
	task automatic send_item(input logic [2:0] fmt, input logic [31:0] num);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fmt;
		value <= num;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		ledger.note_item(fmt, num);
		items_sent++;
		if (fmt > itaf_pkg::FUNC_HEX) begin
			items_ignored++;
		end
	endtask

	// Drops valid and waits until every predicted character has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Random value drawn from a mix of full-width, small and boundary numbers.
	function automatic logic [31:0] random_value();
		logic [31:0] num;
		case ($urandom_range(0, 5))
		0: num = $urandom_range(0, 99);
		1: num = -$urandom_range(1, 1000);
		2: num = $urandom_range(0, 255) | ($urandom() & 32'hFFFF_FF00);
		3: num = $urandom_range(0, 65535) | ($urandom() & 32'hFFFF_0000);
		4: begin
			case ($urandom_range(0, 4))
			0: num = 32'h0000_0000;
			1: num = 32'h0000_0001;
			2: num = 32'hFFFF_FFFF;
			3: num = 32'h7FFF_FFFF;
			default: num = 32'h8000_0000;
			endcase
		end
		default: num = $urandom();
		endcase
		return num;
	endfunction

	// One random phase with the given idle and stall rates.
	task automatic run_random_phase(input int send_pct, input int stall_pct);
		int counted;
		logic [2:0] fmt;
		counted = 0;
		send_idle_pct = send_pct;
		recv_stall_pct <= stall_pct;
		while (counted < PHASE_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				fmt = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
			end else begin
				fmt = 3'($urandom_range(itaf_pkg::FUNC_SDEC, itaf_pkg::FUNC_HEX));
				counted++;
			end
			send_item(fmt, random_value());
		end
	endtask

	// Main sequence: reset, directed items, back-pressure, random phases, final check.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: field extremes, every format and the special cases.
		send_item(itaf_pkg::FUNC_SDEC, 32'h0000_0000);
		send_item(itaf_pkg::FUNC_SDEC, 32'h0000_0001);
		send_item(itaf_pkg::FUNC_SDEC, 32'hFFFF_FFFF);
		send_item(itaf_pkg::FUNC_SDEC, 32'h7FFF_FFFF);
		send_item(itaf_pkg::FUNC_SDEC, 32'h8000_0000);
		send_item(itaf_pkg::FUNC_SDEC, 32'd10);
		send_item(itaf_pkg::FUNC_SDEC, -32'd10);
		send_item(itaf_pkg::FUNC_SDEC, 32'd1000000000);
		send_item(itaf_pkg::FUNC_DEC4, 32'h0000_0000);
		send_item(itaf_pkg::FUNC_DEC4, 32'd9999);
		send_item(itaf_pkg::FUNC_DEC4, 32'd10000);
		send_item(itaf_pkg::FUNC_DEC4, 32'hFFFF_FFFF);
		send_item(itaf_pkg::FUNC_DEC4, 32'hABCD_04D2);
		send_item(itaf_pkg::FUNC_BIN8, 32'h0000_0000);
		send_item(itaf_pkg::FUNC_BIN8, 32'h0000_00FF);
		send_item(itaf_pkg::FUNC_BIN8, 32'h5A5A_5AA5);
		send_item(itaf_pkg::FUNC_BINS, 32'h0000_0000);
		send_item(itaf_pkg::FUNC_BINS, 32'h0000_0001);
		send_item(itaf_pkg::FUNC_BINS, 32'h0000_0080);
		send_item(itaf_pkg::FUNC_BINS, 32'hFFFF_FF00);
		send_item(itaf_pkg::FUNC_HEX, 32'h0000_0000);
		send_item(itaf_pkg::FUNC_HEX, 32'hFFFF_FFFF);
		send_item(itaf_pkg::FUNC_HEX, 32'h1234_569A);
		send_item(FUNC_SPARE_FIRST, 32'h8000_0001);
		send_item(FUNC_SPARE_MID, 32'hFFFF_FFFF);
		send_item(FUNC_SPARE_LAST, 32'h0000_0000);

		// Hold the output off for a long stretch while items keep arriving.
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		for (int i = 0; i < BURST_ITEMS; i++) begin
			send_item(3'($urandom_range(itaf_pkg::FUNC_SDEC, itaf_pkg::FUNC_HEX)),
				random_value());
		end
		wait_drained();

		// Random phases with different idle and stall mixes.
		run_random_phase(0, 0);
		run_random_phase(86, 0);
		run_random_phase(0, 86);
		run_random_phase(25, 25);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d items (%0d with unused selectors) and %0d characters,",
			items_sent, items_ignored, ledger.checked);
		$display("across all five formats, four idle/stall mixes and a long output hold-off.");
		if (ledger.failures == 0 && ledger.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
